FILE: design/mnva_pkg.sv
// Shared types, constants and helpers for the MIDI note voice allocator.
package mnva_pkg;

	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned NOTE_W   = 7;
	localparam int unsigned VIN_W    = 6;
	localparam int unsigned VOUT_W   = 7;
	localparam int unsigned LEN_W    = 8;
	localparam int unsigned VIDX_W   = 4;
	localparam int unsigned VEL_SCALE = 3;
	localparam logic [VOUT_W-1:0] VEL_MAX = 7'd127;

	typedef enum logic {
		ACT_TRIGGER = 1'b0,
		ACT_TICK    = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
		logic [VIN_W-1:0]  velocity;
		logic [LEN_W-1:0]  remaining;
	} voice_t;

	typedef struct packed {
		logic              has_message;
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
		logic [VOUT_W-1:0] velocity;
		logic [VIDX_W-1:0] index;
		logic              dropped;
	} result_t;

	typedef struct packed {
		logic take;
		logic emit_off;
	} head_ctl_t;

	// 3 * velocity, saturated to the MIDI range
	function automatic logic [VOUT_W-1:0] scale_vel(input logic [VIN_W-1:0] v);
		logic [VIN_W+1:0] prod;
		prod = {2'b00, v} + {1'b0, v, 1'b0};
		if (prod > {1'b0, VEL_MAX}) begin
			return VEL_MAX;
		end
		return prod[VOUT_W-1:0];
	endfunction

endpackage

FILE: design/midi_note_voice_allocator.sv
// Top level: voice ring, sequencer and result register of the voice allocator.
//
//   channel   direction  handshake            fields
//   item in   input      start, busy          action channel note velocity length
//   result    output     result_valid strobe  has_message out_channel out_note
//                                             out_velocity voice_index dropped last
//
// An item keeps busy high while the ring rotates once through the head update, the
// final step places the note-on or drop result and the flush step pushes the last one out.
// The next item can be taken at the earliest at the edge that accepts the previous
// item's last result. Each result waits in a holding register until the next one
// or the flush pushes it out; at most one per cycle.
// Reset frees every voice at once. The receiver cannot stall; busy holds off start.
module midi_note_voice_allocator
	import mnva_pkg::*;
#(
	parameter int unsigned NUM_VOICES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [CHAN_W-1:0] channel,
	input  logic [NOTE_W-1:0] note,
	input  logic [VIN_W-1:0]  velocity,
	input  logic [LEN_W-1:0]  length,
	output logic              result_valid,
	output logic              has_message,
	output logic [CHAN_W-1:0] out_channel,
	output logic [NOTE_W-1:0] out_note,
	output logic [VOUT_W-1:0] out_velocity,
	output logic [VIDX_W-1:0] voice_index,
	output logic              dropped,
	output logic              last
);

	localparam int unsigned IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	state_t            state_q, state_d;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     take_idx_q;
	logic              placed_q;
	logic              action_q;
	logic [CHAN_W-1:0] channel_q;
	logic [NOTE_W-1:0] note_q;
	logic [VIN_W-1:0]  velocity_q;
	logic [LEN_W-1:0]  length_q;
	result_t           pend_q;
	logic              pend_valid_q;
	result_t           out_q;
	logic              out_valid_q;
	logic              out_last_q;

	voice_t            ring [NUM_VOICES];
	voice_t            head_next;
	head_ctl_t         head_ctl;
	logic              shift;
	logic              accept;
	logic              scan_end;
	logic [7:0]        idx_ext;
	logic [7:0]        take_ext;

	assign accept   = start && (state_q == ST_IDLE);
	assign shift    = (state_q == ST_SCAN);
	assign scan_end = (idx_q == IW'(NUM_VOICES - 1));
	assign idx_ext  = 8'(idx_q);
	assign take_ext = 8'(take_idx_q);

	for (genvar k = 0; k < NUM_VOICES; k++) begin : g_cell
		voice_t d;
		if (k == NUM_VOICES - 1) begin : g_tail
			assign d = head_next;
		end else begin : g_link
			assign d = ring[k+1];
		end
		mnva_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[k])
		);
	end

	mnva_head u_head (
		.v        (ring[0]),
		.action   (action_q),
		.channel  (channel_q),
		.note     (note_q),
		.velocity (velocity_q),
		.length   (length_q),
		.placed   (placed_q),
		.v_next   (head_next),
		.ctl      (head_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_SCAN;
			ST_SCAN:  if (scan_end) state_d = ST_FINAL;
			ST_FINAL: state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= action;
			channel_q  <= channel;
			note_q     <= note;
			velocity_q <= velocity;
			length_q   <= length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			take_idx_q   <= '0;
			placed_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q        <= '0;
						placed_q     <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (head_ctl.take) begin
						placed_q   <= 1'b1;
						take_idx_q <= idx_q;
					end
					// hand the held result out, keep the new one
					if (head_ctl.emit_off) begin
						out_valid_q  <= pend_valid_q;
						pend_valid_q <= 1'b1;
					end
				end
				ST_FINAL: begin
					if (action_q == ACT_TRIGGER) begin
						out_valid_q  <= pend_valid_q;
						pend_valid_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					out_valid_q  <= pend_valid_q;
					out_last_q   <= pend_valid_q;
					pend_valid_q <= 1'b0;
				end
				default: begin
					pend_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SCAN: begin
				if (head_ctl.emit_off) begin
					out_q              <= pend_q;
					pend_q.has_message <= 1'b1;
					pend_q.channel     <= ring[0].channel;
					pend_q.note        <= ring[0].note;
					pend_q.velocity    <= '0;
					pend_q.index       <= idx_ext[VIDX_W-1:0];
					pend_q.dropped     <= 1'b0;
				end
			end
			ST_FINAL: begin
				if (action_q == ACT_TRIGGER) begin
					out_q <= pend_q;
					if (placed_q) begin
						pend_q.has_message <= 1'b1;
						pend_q.channel     <= channel_q;
						pend_q.note        <= note_q;
						pend_q.velocity    <= scale_vel(velocity_q);
						pend_q.index       <= take_ext[VIDX_W-1:0];
						pend_q.dropped     <= 1'b0;
					end else begin
						pend_q.has_message <= 1'b0;
						pend_q.channel     <= '0;
						pend_q.note        <= '0;
						pend_q.velocity    <= '0;
						pend_q.index       <= '0;
						pend_q.dropped     <= 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				out_q <= pend_q;
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign has_message  = out_q.has_message;
	assign out_channel  = out_q.channel;
	assign out_note     = out_q.note;
	assign out_velocity = out_q.velocity;
	assign voice_index  = out_q.index;
	assign dropped      = out_q.dropped;
	assign last         = out_last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("last result while still working");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && dropped) |-> (!has_message && last))
		else $error("dropped result carries a message or is not last");

	a_final_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |-> ($past(state_q) == ST_SCAN && $past(scan_end)))
		else $error("final step without a full ring rotation");

endmodule

FILE: design/mnva_cell.sv
// One voice cell of the rotating voice ring.
module mnva_cell
	import mnva_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  voice_t d,
	output voice_t q
);

	voice_t voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_q <= '0;
		end else if (shift) begin
			voice_q <= d;
		end
	end

	assign q = voice_q;

endmodule

FILE: design/mnva_head.sv
// Update logic for the voice at the head of the ring: count down, release, place.
module mnva_head
	import mnva_pkg::*;
(
	input  voice_t            v,
	input  logic              action,
	input  logic [CHAN_W-1:0] channel,
	input  logic [NOTE_W-1:0] note,
	input  logic [VIN_W-1:0]  velocity,
	input  logic [LEN_W-1:0]  length,
	input  logic              placed,
	output voice_t            v_next,
	output head_ctl_t         ctl
);

	logic held;
	logic hit;

	assign held = (v.remaining != '0);
	assign hit  = held && (v.channel == channel) && (v.note == note);

	always_comb begin
		v_next = v;
		ctl    = '0;
		if (action == ACT_TICK) begin
			if (held) begin
				v_next.remaining = v.remaining - 1'b1;
				ctl.emit_off     = (v.remaining == LEN_W'(1));
			end
		end else begin
			// release a matching voice, then claim the first free one
			if (hit) begin
				v_next.remaining = '0;
				ctl.emit_off     = 1'b1;
			end
			if ((hit || !held) && !placed) begin
				v_next.channel   = channel;
				v_next.note      = note;
				v_next.velocity  = velocity;
				v_next.remaining = length;
				ctl.take         = 1'b1;
			end
		end
	end

endmodule

FILE: test/mnva_checker.sv
// Checker for the voice allocator: predicts note messages per item and compares results.
`timescale 1ns / 1ps

module mnva_checker
	import mnva_pkg::*;
#(
	parameter int unsigned NUM_VOICES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              action,
	input  logic [CHAN_W-1:0] channel,
	input  logic [NOTE_W-1:0] note,
	input  logic [VIN_W-1:0]  velocity,
	input  logic [LEN_W-1:0]  length,
	input  logic              result_valid,
	input  logic              has_message,
	input  logic [CHAN_W-1:0] out_channel,
	input  logic [NOTE_W-1:0] out_note,
	input  logic [VOUT_W-1:0] out_velocity,
	input  logic [VIDX_W-1:0] voice_index,
	input  logic              dropped,
	input  logic              last,
	output int                errors,
	output int                due,
	output int                n_trig,
	output int                n_tick,
	output int                n_on,
	output int                n_off,
	output int                n_drop,
	output int                n_checked
);

	typedef struct packed {
		result_t msg;
		logic    last;
	} note_event_t;

	logic [CHAN_W-1:0] slot_chan [NUM_VOICES];
	logic [NOTE_W-1:0] slot_note [NUM_VOICES];
	logic [VIN_W-1:0]  slot_vel  [NUM_VOICES];
	logic [LEN_W-1:0]  slot_left [NUM_VOICES];

	note_event_t events_due[$];

	int err_cnt     = 0;
	int due_cnt     = 0;
	int trig_cnt    = 0;
	int tick_cnt    = 0;
	int on_cnt      = 0;
	int off_cnt     = 0;
	int drop_cnt    = 0;
	int checked_cnt = 0;

	assign errors    = err_cnt;
	assign due       = due_cnt;
	assign n_trig    = trig_cnt;
	assign n_tick    = tick_cnt;
	assign n_on      = on_cnt;
	assign n_off     = off_cnt;
	assign n_drop    = drop_cnt;
	assign n_checked = checked_cnt;

	function automatic result_t make_msg(input logic has, input logic [CHAN_W-1:0] ch,
			input logic [NOTE_W-1:0] nt, input logic [VOUT_W-1:0] vel,
			input int unsigned slot, input logic drop);
		result_t m;
		m.has_message = has;
		m.channel     = ch;
		m.note        = nt;
		m.velocity    = vel;
		m.index       = slot[VIDX_W-1:0];
		m.dropped     = drop;
		return m;
	endfunction

	function automatic string show(input note_event_t e);
		return $sformatf("msg=%0d ch=%0d note=%0d vel=%0d voice=%0d drop=%0d last=%0d",
			e.msg.has_message, e.msg.channel, e.msg.note, e.msg.velocity,
			e.msg.index, e.msg.dropped, e.last);
	endfunction

	task automatic flag_error(input string why);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("[%0t] mnva_checker: %s", $time, why);
		end
	endtask

	// Walk the voice table for one accepted item and queue the messages it causes.
	task automatic predict_item(input action_t act, input logic [CHAN_W-1:0] ch,
			input logic [NOTE_W-1:0] nt, input logic [VIN_W-1:0] vel,
			input logic [LEN_W-1:0] len);
		result_t batch[$];
		int unsigned scaled;
		bit placed;
		note_event_t ev;
		placed = 1'b0;
		if (act == ACT_TRIGGER) begin
			trig_cnt++;
			// release any held voice already sounding this note
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (slot_left[v] != '0 && slot_chan[v] == ch && slot_note[v] == nt) begin
					batch.push_back(make_msg(1'b1, slot_chan[v], slot_note[v], '0, v, 1'b0));
					slot_left[v] = '0;
					off_cnt++;
				end
			end
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (!placed && slot_left[v] == '0) begin
					scaled = int'(vel) * VEL_SCALE;
					if (scaled > int'(VEL_MAX)) begin
						scaled = int'(VEL_MAX);
					end
					slot_chan[v] = ch;
					slot_note[v] = nt;
					slot_vel[v]  = vel;
					slot_left[v] = len;
					batch.push_back(make_msg(1'b1, ch, nt, scaled[VOUT_W-1:0], v, 1'b0));
					placed = 1'b1;
					on_cnt++;
				end
			end
			if (!placed) begin
				batch.push_back(make_msg(1'b0, '0, '0, '0, 0, 1'b1));
				drop_cnt++;
			end
		end else begin
			tick_cnt++;
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (slot_left[v] != '0) begin
					slot_left[v] = slot_left[v] - 1'b1;
					if (slot_left[v] == '0) begin
						batch.push_back(make_msg(1'b1, slot_chan[v], slot_note[v], '0, v, 1'b0));
						off_cnt++;
					end
				end
			end
		end
		foreach (batch[k]) begin
			ev.msg  = batch[k];
			ev.last = (k == batch.size() - 1);
			events_due.push_back(ev);
		end
	endtask

	task automatic check_result();
		note_event_t got;
		note_event_t want;
		bit bad;
		got.msg = make_msg(has_message, out_channel, out_note, out_velocity,
			int'(voice_index), dropped);
		got.last = last;
		if (events_due.size() == 0) begin
			flag_error({"unexpected result ", show(got)});
		end else begin
			want = events_due.pop_front();
			checked_cnt++;
			bad = (got.msg.has_message !== want.msg.has_message) ||
				(got.msg.channel !== want.msg.channel) ||
				(got.msg.note !== want.msg.note) ||
				(got.msg.velocity !== want.msg.velocity) ||
				(got.msg.index !== want.msg.index) ||
				(got.msg.dropped !== want.msg.dropped) ||
				(got.last !== want.last);
			if (bad) begin
				flag_error({"mismatch: expected ", show(want), " got ", show(got)});
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				slot_chan[v] = '0;
				slot_note[v] = '0;
				slot_vel[v]  = '0;
				slot_left[v] = '0;
			end
			events_due.delete();
			due_cnt = 0;
		end else begin
			if (result_valid) begin
				check_result();
			end
			if (start && !busy) begin
				predict_item(action_t'(action), channel, note, velocity, length);
			end
			due_cnt = events_due.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Testbench top for the voice allocator: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import mnva_pkg::*;

	localparam int unsigned NUM_VOICES = 16;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              action = 1'b0;
	logic [CHAN_W-1:0] channel = '0;
	logic [NOTE_W-1:0] note = '0;
	logic [VIN_W-1:0]  velocity = '0;
	logic [LEN_W-1:0]  length = '0;
	logic              result_valid;
	logic              has_message;
	logic [CHAN_W-1:0] out_channel;
	logic [NOTE_W-1:0] out_note;
	logic [VOUT_W-1:0] out_velocity;
	logic [VIDX_W-1:0] voice_index;
	logic              dropped;
	logic              last;

	int errors, due, n_trig, n_tick, n_on, n_off, n_drop, n_checked;
	int cycle_cnt = 0;

	midi_note_voice_allocator #(.NUM_VOICES(NUM_VOICES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .channel(channel), .note(note), .velocity(velocity),
		.length(length), .result_valid(result_valid), .has_message(has_message),
		.out_channel(out_channel), .out_note(out_note), .out_velocity(out_velocity),
		.voice_index(voice_index), .dropped(dropped), .last(last)
	);

	mnva_checker #(.NUM_VOICES(NUM_VOICES)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .channel(channel), .note(note), .velocity(velocity),
		.length(length), .result_valid(result_valid), .has_message(has_message),
		.out_channel(out_channel), .out_note(out_note), .out_velocity(out_velocity),
		.voice_index(voice_index), .dropped(dropped), .last(last),
		.errors(errors), .due(due), .n_trig(n_trig), .n_tick(n_tick),
		.n_on(n_on), .n_off(n_off), .n_drop(n_drop), .n_checked(n_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(1, 3);
	endfunction

	// Hold the item on the inputs until the block takes it.
	task automatic send_item(input int gap, input action_t act, input logic [CHAN_W-1:0] ch,
			input logic [NOTE_W-1:0] nt, input logic [VIN_W-1:0] vel,
			input logic [LEN_W-1:0] len);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		channel  <= ch;
		note     <= nt;
		velocity <= vel;
		length   <= len;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_random(input int gap);
		action_t act;
		logic [CHAN_W-1:0] ch;
		logic [NOTE_W-1:0] nt;
		logic [LEN_W-1:0] len;
		act = ($urandom_range(0, 99) < 30) ? ACT_TICK : ACT_TRIGGER;
		// a small pool of notes makes retriggers of held voices common
		if ($urandom_range(0, 1) == 1) begin
			ch = CHAN_W'($urandom_range(0, 1));
			nt = NOTE_W'($urandom_range(60, 63));
		end else begin
			ch = CHAN_W'($urandom);
			nt = NOTE_W'($urandom);
		end
		case ($urandom_range(0, 9))
			0: begin
				len = '0;
			end
			1: begin
				len = LEN_W'($urandom);
			end
			default: begin
				len = LEN_W'($urandom_range(1, 8));
			end
		endcase
		send_item(gap, act, ch, nt, VIN_W'($urandom), len);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on an empty table, other fields set and ignored
		send_item(pick_gap(), ACT_TICK, '1, '1, '1, '1);
		send_item(pick_gap(), ACT_TRIGGER, 4'd0, 7'd0, 6'd0, 8'd1);
		send_item(pick_gap(), ACT_TRIGGER, 4'd15, 7'd127, 6'd63, 8'd255);
		send_item(pick_gap(), ACT_TRIGGER, 4'd5, 7'd60, 6'd42, 8'd3);
		// zero length: note-on, voice stays free; velocity just past saturation
		send_item(pick_gap(), ACT_TRIGGER, 4'd5, 7'd61, 6'd43, 8'd0);
		// retrigger a held note: release then retake
		send_item(pick_gap(), ACT_TRIGGER, 4'd5, 7'd60, 6'd1, 8'd2);
		send_item(pick_gap(), ACT_TICK, '0, '0, '0, '0);
		// fill every free voice, then overflow the table
		for (int i = 0; i < 14; i++) begin
			send_item(pick_gap(), ACT_TRIGGER, CHAN_W'(i), NOTE_W'(20 + i),
				VIN_W'($urandom), 8'd2);
		end
		send_item(pick_gap(), ACT_TRIGGER, 4'd9, 7'd9, 6'd9, 8'd9);
		send_item(pick_gap(), ACT_TRIGGER, 4'd15, 7'd127, 6'd10, 8'd5);
		send_item(pick_gap(), ACT_TICK, '0, '0, '0, '0);
		// most of the table expires on one tick
		send_item(pick_gap(), ACT_TICK, '0, '0, '0, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// a stretch of back-to-back items
			send_random((i >= 60 && i < 80) ? 0 : pick_gap());
		end
		start <= 1'b0;

		do @(posedge clk); while (due != 0 || busy);
		repeat (NUM_VOICES + 4) @(posedge clk);

		$display("tb_top: %0d triggers and %0d ticks sent, %0d results checked",
			n_trig, n_tick, n_checked);
		$display("tb_top: predicted %0d note-ons, %0d note-offs, %0d drops; %0d left over",
			n_on, n_off, n_drop, due);
		if (errors == 0 && due == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/mnva_pkg.sv
design/mnva_cell.sv
design/mnva_head.sv
design/midi_note_voice_allocator.sv
test/mnva_checker.sv
test/tb_top.sv
